@@ hw/rtl/positional_sequence_store_assert.svh @@
// Assertion macros for the positional sequence store.
// Used by the top level; no other dependencies.
`ifndef POSITIONAL_SEQUENCE_STORE_ASSERT_SVH
`define POSITIONAL_SEQUENCE_STORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pss assertion failed");

// Next-cycle implication, disabled while in reset.
`define PSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pss assertion failed");

`endif

@@ hw/rtl/pss_pkg.sv @@
// Shared types and constants for the positional sequence store.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package pss_pkg;

	localparam int CAPACITY      = 16;
	localparam int ELEMENT_WIDTH = 8;

	localparam int KIND_W  = 3;
	localparam int POS_W   = 5;
	localparam int VALUE_W = 8;
	localparam int ELEM_W  = 8;
	localparam int FOUND_W = 5;
	localparam int LEN_W   = 5;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 3'd0,
		KIND_DELETE = 3'd1,
		KIND_GET    = 3'd2,
		KIND_LOCATE = 3'd3,
		KIND_CLEAR  = 3'd4
	} kind_t;

	typedef struct packed {
		logic take_new;
		logic take_left;
		logic take_right;
	} cell_ctl_t;

endpackage

@@ hw/rtl/pss_cell.sv @@
// One storage cell of the sequence row: holds an element, shifts from a neighbor.
// Depends on pss_pkg for the cell control struct.
`timescale 1ns / 1ps

module pss_cell #(
	parameter int ELEMENT_WIDTH = pss_pkg::ELEMENT_WIDTH
) (
	input  logic                     clk,
	input  pss_pkg::cell_ctl_t       ctl,
	input  logic [ELEMENT_WIDTH-1:0] left_data,
	input  logic [ELEMENT_WIDTH-1:0] right_data,
	input  logic [ELEMENT_WIDTH-1:0] operand,
	output logic [ELEMENT_WIDTH-1:0] data,
	output logic                     match
);

	logic [ELEMENT_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.take_new) begin
			data_q <= operand;
		end else if (ctl.take_left) begin
			data_q <= left_data;
		end else if (ctl.take_right) begin
			data_q <= right_data;
		end
	end

	assign data  = data_q;
	assign match = (data_q == operand);

endmodule

@@ hw/rtl/pss_first_hit.sv @@
// First-match encoder: 1-based position of the lowest set hit bit, 0 if none.
// Depends on pss_pkg only for its default width.
`timescale 1ns / 1ps

module pss_first_hit #(
	parameter int CAPACITY = pss_pkg::CAPACITY,
	parameter int PW       = $clog2(CAPACITY + 1)
) (
	input  logic [CAPACITY-1:0] hits,
	output logic [PW-1:0]       position
);

	logic [CAPACITY-1:0] lowest;

	// isolate lowest set bit
	assign lowest = hits & (~hits + CAPACITY'(1));

	always_comb begin
		position = '0;
		for (int b = 0; b < PW; b++) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if ((((i + 1) >> b) & 1) != 0) begin
					position[b] = position[b] | lowest[i];
				end
			end
		end
	end

endmodule

@@ hw/rtl/positional_sequence_store.sv @@
// Top level of the positional sequence store: a row of shifting cells.
// Depends on pss_pkg, pss_cell, pss_first_hit and the assertion macro header.
//
// Usage:
//   Request channel: drive kind, position and value with start high; a
//   transaction is taken at each rising edge with start high and busy low.
//   busy stays low, so one request is taken every cycle.
//   Result channel: done pulses for one cycle, registered at the request
//   edge, with ok, element, found_at and length. Results come in request
//   order; the receiver cannot stall and must take each one as it appears.
//   Throughput is 1 request per cycle: each cell shifts from
//   its left or right neighbor in the same edge, and all cells compare
//   against the locate value in parallel ahead of the first-match encoder.
//   Positions are 1-based; length, found_at and element are reported modulo
//   their port widths.
//   Reset (arst_n low) empties the store at once and drops any pending
//   result; cell contents are not cleared, as only held positions are read.
//   An insert, delete or get whose position is out of range, or an insert
//   into a full store, returns ok low and leaves the store unchanged.
`timescale 1ns / 1ps

module positional_sequence_store #(
	parameter int CAPACITY      = pss_pkg::CAPACITY,
	parameter int ELEMENT_WIDTH = pss_pkg::ELEMENT_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [pss_pkg::KIND_W-1:0]  kind,
	input  logic [pss_pkg::POS_W-1:0]   position,
	input  logic [pss_pkg::VALUE_W-1:0] value,
	output logic                        done,
	output logic                        ok,
	output logic [pss_pkg::ELEM_W-1:0]  element,
	output logic [pss_pkg::FOUND_W-1:0] found_at,
	output logic [pss_pkg::LEN_W-1:0]   length
);

	`include "positional_sequence_store_assert.svh"

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int XW = ((CW > pss_pkg::POS_W) ? CW : pss_pkg::POS_W) + 1;

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	logic          accept;

	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_x;
	logic [XW-1:0] idx_x;
	logic          pos_nz;
	logic          in_range;
	logic          ins_ok;
	logic          ins_go;
	logic          del_go;

	logic [ELEMENT_WIDTH-1:0] operand;
	logic [ELEMENT_WIDTH-1:0] cell_data [CAPACITY];
	logic [ELEMENT_WIDTH-1:0] rd_data;
	logic [CAPACITY-1:0]      cell_eq;
	logic [CAPACITY-1:0]      hits;
	logic [CW-1:0]            hit_pos;

	logic                        ok_nxt;
	logic [pss_pkg::ELEM_W-1:0]  elem_nxt;
	logic [pss_pkg::FOUND_W-1:0] found_nxt;

	logic                        done_q;
	logic                        ok_q;
	logic [pss_pkg::ELEM_W-1:0]  element_q;
	logic [pss_pkg::FOUND_W-1:0] found_at_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign operand  = ELEMENT_WIDTH'(value);
	assign pos_x    = XW'(position);
	assign cnt_x    = XW'(count_q);
	assign idx_x    = pos_x - XW'(1);
	assign pos_nz   = (pos_x != '0);
	assign in_range = pos_nz && (pos_x <= cnt_x);
	assign ins_ok   = pos_nz && (pos_x <= cnt_x + XW'(1)) && (cnt_x < XW'(CAPACITY));
	assign ins_go   = accept && (kind == pss_pkg::KIND_INSERT) && ins_ok;
	assign del_go   = accept && (kind == pss_pkg::KIND_DELETE) && in_range;

	assign rd_data = cell_data[idx_x[IW-1:0]];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		pss_pkg::cell_ctl_t       ctl;
		logic [ELEMENT_WIDTH-1:0] left_data;
		logic [ELEMENT_WIDTH-1:0] right_data;

		assign ctl.take_new   = ins_go && (XW'(i) == idx_x);
		assign ctl.take_left  = ins_go && (XW'(i) > idx_x);
		assign ctl.take_right = del_go && (XW'(i) >= idx_x);

		if (i == 0) begin : g_first
			assign left_data = operand;
		end else begin : g_inner_left
			assign left_data = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_data = '0;
		end else begin : g_inner_right
			assign right_data = cell_data[i+1];
		end

		pss_cell #(
			.ELEMENT_WIDTH(ELEMENT_WIDTH)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.left_data (left_data),
			.right_data(right_data),
			.operand   (operand),
			.data      (cell_data[i]),
			.match     (cell_eq[i])
		);

		assign hits[i] = cell_eq[i] && (XW'(i) < cnt_x);
	end

	pss_first_hit #(
		.CAPACITY(CAPACITY),
		.PW      (CW)
	) u_first_hit (
		.hits    (hits),
		.position(hit_pos)
	);

	always_comb begin
		ok_nxt    = 1'b0;
		elem_nxt  = '0;
		found_nxt = '0;
		count_nxt = count_q;
		case (kind)
			pss_pkg::KIND_INSERT: begin
				ok_nxt = ins_ok;
				if (ins_ok) begin
					count_nxt = count_q + CW'(1);
				end
			end
			pss_pkg::KIND_DELETE: begin
				ok_nxt = in_range;
				if (in_range) begin
					elem_nxt  = pss_pkg::ELEM_W'(rd_data);
					count_nxt = count_q - CW'(1);
				end
			end
			pss_pkg::KIND_GET: begin
				ok_nxt = in_range;
				if (in_range) begin
					elem_nxt = pss_pkg::ELEM_W'(rd_data);
				end
			end
			pss_pkg::KIND_LOCATE: begin
				ok_nxt    = |hits;
				found_nxt = pss_pkg::FOUND_W'(hit_pos);
			end
			pss_pkg::KIND_CLEAR: begin
				ok_nxt    = 1'b1;
				count_nxt = '0;
			end
			default: begin
				ok_nxt = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q       <= ok_nxt;
			element_q  <= elem_nxt;
			found_at_q <= found_nxt;
		end
	end

	assign done     = done_q;
	assign ok       = ok_q;
	assign element  = element_q;
	assign found_at = found_at_q;
	assign length   = pss_pkg::LEN_W'(count_q);

	`PSS_ASSERT_NEXT(a_done_follows_accept, clk, arst_n, accept, done)
	`PSS_ASSERT_NEXT(a_no_spurious_done, clk, arst_n, !accept, !done)
	`PSS_ASSERT_NOW(a_count_bounded, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY))
	`PSS_ASSERT_NEXT(a_clear_empties, clk, arst_n,
		accept && (kind == pss_pkg::KIND_CLEAR), count_q == '0)
	`PSS_ASSERT_NOW(a_found_means_ok, clk, arst_n, done && (found_at != '0), ok)

endmodule
